>>> rtl/core/pgl1np_pkg.sv
// Shared types and constants for the per-group L1 nearest point block.
package pgl1np_pkg;

	localparam int COORD_BITS   = 32;
	localparam int NUM_COORDS   = 4;
	localparam int GROUP_BITS   = 4;
	localparam int EXTRA_BITS   = 32;
	localparam int DIST_BITS    = 35;
	localparam int CFG_IDX_BITS = 2;
	localparam int ABS_BITS     = COORD_BITS;
	localparam int PAIR_BITS    = COORD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// Input transaction
	typedef struct packed {
		logic [GROUP_BITS-1:0]        group;
		logic signed [COORD_BITS-1:0] coord_0;
		logic signed [COORD_BITS-1:0] coord_1;
		logic signed [COORD_BITS-1:0] coord_2;
		logic signed [COORD_BITS-1:0] coord_3;
		logic signed [EXTRA_BITS-1:0] extra_value;
		logic                         last_point;
	} point_t;

	// Output transaction
	typedef struct packed {
		logic [GROUP_BITS-1:0]        out_group;
		logic                         found;
		logic signed [COORD_BITS-1:0] best_coord_0;
		logic signed [COORD_BITS-1:0] best_coord_1;
		logic signed [COORD_BITS-1:0] best_coord_2;
		logic signed [COORD_BITS-1:0] best_coord_3;
		logic signed [EXTRA_BITS-1:0] best_extra;
		logic [DIST_BITS-1:0]         best_distance;
		logic                         last_result;
	} result_t;

	// One stored best point per group
	typedef struct packed {
		logic [DIST_BITS-1:0]                   best_dist;
		logic [NUM_COORDS-1:0][COORD_BITS-1:0] coords;
		logic [EXTRA_BITS-1:0]                  extra;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic diff_en;
		logic sum_en;
		logic commit;
		logic drain_sel;
		logic out_load;
		logic clear_seen;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic item_last;
	} dp_status_t;

endpackage

>>> rtl/core/per_group_l1_nearest_point.sv
// Top level of the per-group L1 nearest point block.
//
// Points enter on the point channel (valid/ready), each with a group index,
// four signed Q16.16 coordinates, an extra value and a last flag. For each
// group the block keeps the point with the smallest L1 distance to the
// reference point in cfg registers 0..3; a tie keeps the earlier point.
// A point whose group is NUM_GROUPS or above is ignored apart from its flag.
// Each point passes through accept, absolute differences, pairwise sums,
// then final sum, compare and store write; the store is a RAM with one
// registered read port, read at the point's group at accept.
// A point flagged last is followed by a drain of NUM_GROUPS transactions on
// the result channel in group order, each a RAM read, then a load of the
// result register; found=0 and zero fields mark an empty group, and
// last_result marks the highest group. The group occupancy bits clear as
// the last result loads.
// A stalled receiver holds the result register; the drain waits, and after
// the final load new points are accepted while that result is still pending.
// Reset clears the reference registers, the occupancy bits and all control.
// NUM_GROUPS ranges from 1 to 16.
module per_group_l1_nearest_point #(
	parameter int NUM_GROUPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [pgl1np_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [pgl1np_pkg::COORD_BITS-1:0]   cfg_data,
	input  logic                                point_valid,
	output logic                                point_ready,
	input  pgl1np_pkg::point_t                  point,
	output logic                                result_valid,
	input  logic                                result_ready,
	output pgl1np_pkg::result_t                 result
);
	import pgl1np_pkg::*;

	localparam int IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	ctrl_cmd_t        cmd;
	dp_status_t       status;
	logic [IDX_W-1:0] drain_idx;

	pgl1np_ctrl #(
		.NUM_GROUPS (NUM_GROUPS),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd),
		.drain_idx    (drain_idx)
	);

	pgl1np_dp #(
		.NUM_GROUPS (NUM_GROUPS),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point     (point),
		.cmd       (cmd),
		.drain_idx (drain_idx),
		.status    (status),
		.result    (result)
	);

endmodule

>>> rtl/core/pgl1np_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pgl1np_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/pgl1np_ctrl.sv
// Controller: sequences item scoring, store update and the per-group drain.
module pgl1np_ctrl #(
	parameter int NUM_GROUPS = 16,
	parameter int IDX_W      = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   point_valid,
	output logic                   point_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	input  pgl1np_pkg::dp_status_t status,
	output pgl1np_pkg::ctrl_cmd_t  cmd,
	output logic [IDX_W-1:0]       drain_idx
);
	import pgl1np_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SUM,
		ST_CMP,
		ST_DRD,
		ST_DLD
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_GROUPS - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             last_group;

	assign last_group = (idx_q == LAST_IDX);

	// Decode commands from the current state and the handshake inputs
	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && point_valid;
		cmd.diff_en    = (state_q == ST_DIFF);
		cmd.sum_en     = (state_q == ST_SUM);
		cmd.commit     = (state_q == ST_CMP);
		cmd.drain_sel  = (state_q == ST_DRD) || (state_q == ST_DLD);
		cmd.out_load   = (state_q == ST_DLD) && (!out_valid_q || result_ready);
		cmd.clear_seen = cmd.out_load && last_group;
	end

	assign point_ready  = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign drain_idx    = idx_q;

	// State, drain counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (point_valid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CMP;
				ST_CMP: begin
					if (status.item_last) begin
						idx_q   <= '0;
						state_q <= ST_DRD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRD: state_q <= ST_DLD;
				ST_DLD: begin
					if (cmd.out_load) begin
						if (last_group) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/pgl1np_dp.sv
// Datapath: reference registers, L1 distance stages, group store and result register.
module pgl1np_dp #(
	parameter int NUM_GROUPS = 16,
	parameter int IDX_W      = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_en,
	input  logic [pgl1np_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [pgl1np_pkg::COORD_BITS-1:0]    cfg_data,
	input  pgl1np_pkg::point_t                   point,
	input  pgl1np_pkg::ctrl_cmd_t                cmd,
	input  logic [IDX_W-1:0]                     drain_idx,
	output pgl1np_pkg::dp_status_t               status,
	output pgl1np_pkg::result_t                  result
);
	import pgl1np_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_GROUPS - 1);

	coord_t                  ref_q [NUM_COORDS];
	logic [GROUP_BITS-1:0]   group_q;
	coord_t                  coords_q [NUM_COORDS];
	logic [EXTRA_BITS-1:0]   extra_q;
	logic                    last_q;
	logic [ABS_BITS-1:0]     absd_s1 [NUM_COORDS];
	logic [PAIR_BITS-1:0]    pair_s2 [NUM_COORDS/2];
	logic [NUM_GROUPS-1:0]   seen_q;
	result_t                 result_q;

	coord_t                  pt_coord [NUM_COORDS];
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        grp_idx;
	entry_t                  rd_entry;
	entry_t                  wr_entry;
	logic                    wr_en;
	logic                    in_range;
	logic [DIST_BITS-1:0]    item_dist;
	logic                    found;

	assign pt_coord[0] = point.coord_0;
	assign pt_coord[1] = point.coord_1;
	assign pt_coord[2] = point.coord_2;
	assign pt_coord[3] = point.coord_3;

	// Reference point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COORDS; k++) begin
				ref_q[k] <= '0;
			end
		end else if (cfg_en && (int'(cfg_index) < NUM_COORDS)) begin
			ref_q[cfg_index] <= cfg_data;
		end
	end

	// Hold the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			group_q  <= point.group;
			extra_q  <= point.extra_value;
			last_q   <= point.last_point;
			coords_q <= pt_coord;
		end
	end

	assign status.item_last = last_q;

	// Stage 1: per-coordinate absolute difference
	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			for (int k = 0; k < NUM_COORDS; k++) begin
				logic signed [COORD_BITS:0] d;
				d = {coords_q[k][COORD_BITS-1], coords_q[k]} -
				    {ref_q[k][COORD_BITS-1], ref_q[k]};
				absd_s1[k] <= d[COORD_BITS] ? ABS_BITS'(-d) : ABS_BITS'(d);
			end
		end
	end

	// Stage 2: pairwise sums
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			for (int p = 0; p < NUM_COORDS / 2; p++) begin
				pair_s2[p] <= PAIR_BITS'(absd_s1[2*p]) + PAIR_BITS'(absd_s1[2*p+1]);
			end
		end
	end

	// Final sum; four 32-bit magnitudes stay below the distance field maximum
	assign item_dist = DIST_BITS'(pair_s2[0]) + DIST_BITS'(pair_s2[1]);

	// Store update: replace only on a first point or a strictly smaller distance
	assign grp_idx  = group_q[IDX_W-1:0];
	assign in_range = (int'(group_q) < NUM_GROUPS);
	assign wr_en    = cmd.commit && in_range &&
	                  (!seen_q[grp_idx] || (item_dist < rd_entry.best_dist));

	always_comb begin
		wr_entry.best_dist = item_dist;
		wr_entry.extra     = extra_q;
		for (int k = 0; k < NUM_COORDS; k++) begin
			wr_entry.coords[k] = coords_q[k];
		end
	end

	// Read address: drain counter, incoming group, or held group
	always_comb begin
		priority if (cmd.drain_sel) begin
			rd_addr = drain_idx;
		end else if (cmd.capture) begin
			rd_addr = point.group[IDX_W-1:0];
		end else begin
			rd_addr = grp_idx;
		end
	end

	pgl1np_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NUM_GROUPS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (grp_idx),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	// Group occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.clear_seen) begin
			seen_q <= '0;
		end else if (wr_en) begin
			seen_q[grp_idx] <= 1'b1;
		end
	end

	assign found = seen_q[drain_idx];

	// Result register; empty groups report zeros
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.out_group     <= GROUP_BITS'(drain_idx);
			result_q.found         <= found;
			result_q.best_coord_0  <= found ? rd_entry.coords[0] : '0;
			result_q.best_coord_1  <= found ? rd_entry.coords[1] : '0;
			result_q.best_coord_2  <= found ? rd_entry.coords[2] : '0;
			result_q.best_coord_3  <= found ? rd_entry.coords[3] : '0;
			result_q.best_extra    <= found ? rd_entry.extra : '0;
			result_q.best_distance <= found ? rd_entry.best_dist : '0;
			result_q.last_result   <= (drain_idx == LAST_IDX);
		end
	end

	assign result = result_q;

endmodule
